[design/rgb_box_blur_clipped_macros.svh]
// Assertion macros for the checks of the box blur block.
// Depends on nothing; included by the checker module.
`ifndef RGB_BOX_BLUR_CLIPPED_MACROS_SVH
`define RGB_BOX_BLUR_CLIPPED_MACROS_SVH

// Implication checked while reset is released.
`define RBB_ASSERT_ON(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbb assertion failed");

// Implication checked on every edge, reset included.
`define RBB_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("rbb assertion failed");

`endif

[design/rbb_pkg.sv]
// Package of the box blur block: word types, register indexes and fixed widths.
// Depends on nothing; used by the front, back, top level and checker modules.
package rbb_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } t_in;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       frame_last;
    } t_out;

    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_KERNEL_RADIUS = 2'd2;

    localparam int CFG_DATA_W = 13;
    localparam int ROW_W      = 13;
    localparam int RAD_W      = 3;
    localparam int SUM_W      = 16;
    localparam int CNT_W      = 8;
    localparam int PIX_W      = 24;

endpackage

[design/rbb_line_mem.sv]
// Line store of original pixels: one write port, one registered read port.
// Depends on nothing.
module rbb_line_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/rbb_fifo.sv]
// Short first-in first-out queue used between the parts of the box blur block.
// Depends on nothing.
module rbb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_q [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             do_wr, do_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_rdata = r_q[r_rp];

    function automatic logic [PW-1:0] inc_ptr(input logic [PW-1:0] p);
        inc_ptr = (32'(p) == DEPTH - 1) ? '0 : PW'(32'(p) + 1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_q[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= inc_ptr(r_wp);
            end
            if (do_rd) begin
                r_rp <= inc_ptr(r_rp);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[design/rbb_front.sv]
// Front part of the box blur: configuration registers, input positions, line
// store writes and the decision which output pixel is due. Uses rbb_pkg.
module rbb_front import rbb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7,
    parameter int AW         = 14,
    parameter int CW         = 10,
    parameter int WW         = 11,
    parameter int JW         = 38
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_in                   i_in,
    output logic                  o_full,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_mem_we,
    output logic [AW-1:0]         o_mem_waddr,
    output logic [PIX_W-1:0]      o_mem_wdata,
    output logic                  o_job_wr,
    output logic [JW-1:0]         o_job,
    input  logic                  i_job_full,
    input  logic                  i_back_busy,
    output logic [WW-1:0]         o_cur_w,
    output logic [ROW_W-1:0]      o_cur_h,
    output logic [RAD_W-1:0]      o_cur_r
);

    localparam int RING = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
    localparam int LW   = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);

    logic [10:0]      r_cfg_w;
    logic [12:0]      r_cfg_h;
    logic [2:0]       r_cfg_r;
    logic             r_active;
    logic [WW-1:0]    r_cw;
    logic [ROW_W-1:0] r_ch;
    logic [RAD_W-1:0] r_cr;
    logic [LW-1:0]    r_lag;
    logic [ROW_W:0]   r_in_row;
    logic [CW-1:0]    r_in_col;
    logic [AW-1:0]    r_in_ptr;
    logic [ROW_W-1:0] r_out_row;
    logic [CW-1:0]    r_out_col;
    logic [AW-1:0]    r_out_ptr;
    logic [LW-1:0]    r_dist;

    logic [WW-1:0]    w_cl, eff_w;
    logic [ROW_W-1:0] h_cl, eff_h;
    logic [RAD_W-1:0] r_cl;
    logic [LW-1:0]    lag_cl, eff_lag, dist_inc;
    logic             accept, in_frame, skip, emit, last, in_col_end, out_col_end;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (32'(p) == RING - 1) ? '0 : AW'(32'(p) + 1);
    endfunction

    // Clamp the programmed values to what the hardware supports.
    always_comb begin
        if (r_cfg_w == '0) begin
            w_cl = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_cl = WW'(MAX_WIDTH);
        end else begin
            w_cl = WW'(r_cfg_w);
        end
        h_cl   = (r_cfg_h == '0) ? ROW_W'(1) : r_cfg_h;
        r_cl   = (32'(r_cfg_r) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : r_cfg_r;
        lag_cl = LW'(32'(r_cl) * 32'(w_cl) + 32'(r_cl));
    end

    assign eff_w   = r_active ? r_cw  : w_cl;
    assign eff_h   = r_active ? r_ch  : h_cl;
    assign eff_lag = r_active ? r_lag : lag_cl;

    assign o_full      = i_job_full || (!r_active && i_back_busy);
    assign accept      = i_push && !o_full;
    assign in_frame    = (r_in_row < {1'b0, eff_h});
    assign skip        = in_frame && i_in.action;
    assign dist_inc    = r_dist + LW'(1);
    assign emit        = !skip && (dist_inc == eff_lag + LW'(1));
    assign in_col_end  = (32'(r_in_col) == 32'(eff_w) - 1);
    assign out_col_end = (32'(r_out_col) == 32'(eff_w) - 1);
    assign last        = out_col_end && (r_out_row == eff_h - ROW_W'(1));

    assign o_mem_we    = accept && in_frame && !i_in.action;
    assign o_mem_waddr = r_in_ptr;
    assign o_mem_wdata = {i_in.in_red, i_in.in_green, i_in.in_blue};
    assign o_job_wr    = accept && emit;
    assign o_job       = {last, r_out_ptr, r_out_col, r_out_row};
    assign o_cur_w     = r_cw;
    assign o_cur_h     = r_ch;
    assign o_cur_r     = r_cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= 11'd512;
            r_cfg_h <= 13'd512;
            r_cfg_r <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:   r_cfg_w <= i_cfg_wdata[10:0];
                REG_FRAME_HEIGHT:  r_cfg_h <= i_cfg_wdata[12:0];
                REG_KERNEL_RADIUS: r_cfg_r <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_cw      <= WW'(1);
            r_ch      <= ROW_W'(1);
            r_cr      <= '0;
            r_lag     <= '0;
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_in_ptr  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
            r_out_ptr <= '0;
            r_dist    <= '0;
        end else if (accept) begin
            if (!r_active) begin
                r_cw     <= w_cl;
                r_ch     <= h_cl;
                r_cr     <= r_cl;
                r_lag    <= lag_cl;
                r_active <= 1'b1;
            end
            if (!skip) begin
                r_in_ptr <= ptr_inc(r_in_ptr);
                if (in_col_end) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + (ROW_W+1)'(1);
                end else begin
                    r_in_col <= r_in_col + CW'(1);
                end
                if (!emit) begin
                    r_dist <= dist_inc;
                end else if (last) begin
                    // The frame is complete: every position starts over.
                    r_active  <= 1'b0;
                    r_in_row  <= '0;
                    r_in_col  <= '0;
                    r_in_ptr  <= '0;
                    r_out_row <= '0;
                    r_out_col <= '0;
                    r_out_ptr <= '0;
                    r_dist    <= '0;
                end else begin
                    r_out_ptr <= ptr_inc(r_out_ptr);
                    if (out_col_end) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + ROW_W'(1);
                    end else begin
                        r_out_col <= r_out_col + CW'(1);
                    end
                end
            end
        end
    end

endmodule

[design/rbb_back.sv]
// Back part of the box blur: walks the clipped window in the line store,
// sums the three channels and divides by the window size. Uses rbb_pkg.
module rbb_back import rbb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7,
    parameter int AW         = 14,
    parameter int CW         = 10,
    parameter int WW         = 11,
    parameter int JW         = 38
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [JW-1:0]    i_job,
    input  logic             i_job_empty,
    output logic             o_job_rd,
    input  logic [WW-1:0]    i_cur_w,
    input  logic [ROW_W-1:0] i_cur_h,
    input  logic [RAD_W-1:0] i_cur_r,
    output logic             o_mem_re,
    output logic [AW-1:0]    o_mem_raddr,
    input  logic [PIX_W-1:0] i_mem_rdata,
    output logic             o_out_wr,
    output t_out             o_out,
    input  logic             i_out_full,
    output logic             o_busy
);

    localparam int RING = (2 * MAX_RADIUS + 2) * MAX_WIDTH;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_BND   = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_BASE  = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]             r_state;
    logic [ROW_W-1:0]       r_row;
    logic [CW-1:0]          r_col;
    logic [AW-1:0]          r_ptr, r_off, r_addr, r_rbase;
    logic                   r_last;
    logic [3:0]             r_nrows, r_ncols, r_x, r_y, r_step;
    logic [RAD_W-1:0]       r_dr, r_dc;
    logic [CNT_W-1:0]       r_cnt;
    logic [2:0][SUM_W-1:0]  r_sum;
    logic [2:0][CNT_W-1:0]  r_rem;
    logic                   r_rd_vld;

    logic [ROW_W:0]   row_x, row_lo, row_hi, r_x14;
    logic [CW:0]      col_x, col_lo, col_hi, c_x;
    logic [AW-1:0]    start;

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [31:0] b);
        logic [31:0] s;
        s = 32'(a) + b;
        add_wrap = (s >= RING) ? AW'(s - RING) : AW'(s);
    endfunction

    // Clip the window against the frame edges.
    always_comb begin
        row_x  = {1'b0, r_row};
        r_x14  = (ROW_W+1)'(i_cur_r);
        row_lo = (row_x >= r_x14) ? row_x - r_x14 : '0;
        row_hi = (row_x + r_x14 < {1'b0, i_cur_h}) ? row_x + r_x14
                                                   : {1'b0, i_cur_h} - (ROW_W+1)'(1);
        col_x  = {1'b0, r_col};
        c_x    = (CW+1)'(i_cur_r);
        col_lo = (col_x >= c_x) ? col_x - c_x : '0;
        col_hi = (32'(col_x) + 32'(c_x) < 32'(i_cur_w)) ? col_x + c_x
                                                        : (CW+1)'(32'(i_cur_w) - 1);
        start  = (r_ptr >= r_off) ? r_ptr - r_off : AW'(32'(r_ptr) + RING - 32'(r_off));
    end

    // A job still waiting in the queue counts as work in progress, since it
    // reads the frame geometry of the current frame.
    assign o_busy      = (r_state != S_IDLE) || !i_job_empty;
    assign o_job_rd    = (r_state == S_IDLE) && !i_job_empty;
    assign o_mem_re    = (r_state == S_RD);
    assign o_mem_raddr = r_addr;
    assign o_out_wr    = (r_state == S_OUT) && !i_out_full;
    assign o_out       = '{out_blue: r_sum[0][7:0], out_green: r_sum[1][7:0],
                           out_red: r_sum[2][7:0], frame_last: r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == S_RD);
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_state <= S_BND;
                    end
                end
                S_BND:   r_state <= S_MUL;
                S_MUL:   r_state <= S_BASE;
                S_BASE:  r_state <= S_RD;
                S_RD: begin
                    if (r_x == r_ncols - 4'd1 && r_y == r_nrows - 4'd1) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: r_state <= S_DIV;
                S_DIV: begin
                    if (r_step == 4'd15) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic [CNT_W:0] t;
        if (o_job_rd) begin
            {r_last, r_ptr, r_col, r_row} <= i_job;
        end
        if (r_state == S_BND) begin
            r_dr    <= RAD_W'(row_x - row_lo);
            r_dc    <= RAD_W'(col_x - col_lo);
            r_nrows <= 4'(row_hi - row_lo + (ROW_W+1)'(1));
            r_ncols <= 4'(col_hi - col_lo + (CW+1)'(1));
        end
        if (r_state == S_MUL) begin
            r_off <= AW'(32'(r_dr) * 32'(i_cur_w) + 32'(r_dc));
        end
        if (r_state == S_BASE) begin
            r_addr  <= start;
            r_rbase <= start;
            r_x     <= '0;
            r_y     <= '0;
            r_cnt   <= CNT_W'(r_nrows) * CNT_W'(r_ncols);
            r_sum   <= '0;
        end
        if (r_state == S_RD) begin
            if (r_x == r_ncols - 4'd1) begin
                r_x     <= '0;
                r_y     <= r_y + 4'd1;
                r_rbase <= add_wrap(r_rbase, 32'(i_cur_w));
                r_addr  <= add_wrap(r_rbase, 32'(i_cur_w));
            end else begin
                r_x    <= r_x + 4'd1;
                r_addr <= add_wrap(r_addr, 32'd1);
            end
        end
        if (r_rd_vld) begin
            for (int c = 0; c < 3; c++) begin
                r_sum[c] <= r_sum[c] + SUM_W'(i_mem_rdata[8*c +: 8]);
            end
        end
        if (r_state == S_FLUSH) begin
            r_step <= '0;
            r_rem  <= '0;
        end
        // Restoring division, one quotient bit per cycle; the sum register
        // shifts the dividend out and the quotient in.
        if (r_state == S_DIV) begin
            r_step <= r_step + 4'd1;
            for (int c = 0; c < 3; c++) begin
                t = {r_rem[c], r_sum[c][SUM_W-1]};
                if (t >= {1'b0, r_cnt}) begin
                    r_rem[c] <= CNT_W'(t - {1'b0, r_cnt});
                    r_sum[c] <= {r_sum[c][SUM_W-2:0], 1'b1};
                end else begin
                    r_rem[c] <= t[CNT_W-1:0];
                    r_sum[c] <= {r_sum[c][SUM_W-2:0], 1'b0};
                end
            end
        end
    end

endmodule

[design/rgb_box_blur_clipped.sv]
// Top level of the RGB box blur with clipped borders.
// Depends on rbb_pkg, rbb_front, rbb_back, rbb_fifo and rbb_line_mem.
//
// Usage: pixels enter in raster order through a queue style port: a word is
// taken when push is high and full is low. Each result word leaves through a
// second queue port: it is shown while empty is low and taken when pop is
// high. Frame width, height and kernel radius are written on the plain
// configuration port while the block is idle; they are sampled by the first
// word of each frame. After the last pixel, r*W + r drain words push out
// the rest of the frame. The word with frame_last set closes the frame.
// Timing: the front part takes a word each cycle while the job queue has
// room. Each result is built by the back part from its n in-frame window
// positions (at most 225): the line store gives one pixel per cycle and
// the divider one quotient bit per cycle. The back part takes no new job
// until its result is written, so the sustained rate is set by that loop.
// The first word of a frame waits until the back part ends the previous one.
// Reset clears the positions and queues and restores the register defaults
// (512, 512, 1); the line store is not cleared. A stalled receiver fills the
// two word result queue, then the back part and job queue, then full rises.
module rgb_box_blur_clipped import rbb_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    input  t_in                   i_in,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Ring of original pixels, sized so that every window still needed stays.
    localparam int RING = (2 * MAX_RADIUS + 2) * MAX_WIDTH;
    localparam int AW   = $clog2(RING);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int JW   = 1 + AW + CW + ROW_W;
    localparam int OW   = $bits(t_out);

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [PIX_W-1:0] mem_wdata, mem_rdata;
    logic             job_wr, job_rd, job_full, job_empty, back_busy;
    logic [JW-1:0]    job_in, job_out;
    logic [WW-1:0]    cur_w;
    logic [ROW_W-1:0] cur_h;
    logic [RAD_W-1:0] cur_r;
    logic             out_wr, out_full;
    t_out             back_out;
    logic [OW-1:0]    out_q;

    rbb_front #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS),
        .AW(AW), .CW(CW), .WW(WW), .JW(JW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_in(i_in), .o_full(full),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .o_mem_we(mem_we), .o_mem_waddr(mem_waddr), .o_mem_wdata(mem_wdata),
        .o_job_wr(job_wr), .o_job(job_in), .i_job_full(job_full),
        .i_back_busy(back_busy),
        .o_cur_w(cur_w), .o_cur_h(cur_h), .o_cur_r(cur_r)
    );

    rbb_line_mem #(.DEPTH(RING), .AW(AW), .DW(PIX_W)) u_mem (
        .i_clk(i_clk),
        .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_re(mem_re), .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );

    // Job queue between the front and back parts.
    rbb_fifo #(.WIDTH(JW), .DEPTH(2)) u_job_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(job_wr), .i_wdata(job_in), .i_rd(job_rd), .o_rdata(job_out),
        .o_full(job_full), .o_empty(job_empty)
    );

    rbb_back #(
        .MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS),
        .AW(AW), .CW(CW), .WW(WW), .JW(JW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job(job_out), .i_job_empty(job_empty), .o_job_rd(job_rd),
        .i_cur_w(cur_w), .i_cur_h(cur_h), .i_cur_r(cur_r),
        .o_mem_re(mem_re), .o_mem_raddr(mem_raddr), .i_mem_rdata(mem_rdata),
        .o_out_wr(out_wr), .o_out(back_out), .i_out_full(out_full),
        .o_busy(back_busy)
    );

    // Result queue that decouples the back part from the receiver.
    rbb_fifo #(.WIDTH(OW), .DEPTH(2)) u_out_q (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr(out_wr), .i_wdata(back_out), .i_rd(pop), .o_rdata(out_q),
        .o_full(out_full), .o_empty(empty)
    );

    assign o_out = t_out'(out_q);

endmodule

[design/rbb_checker.sv]
// Port level checks of the box blur top level, attached by a bind statement.
// Depends on rbb_pkg and rgb_box_blur_clipped_macros.svh.
`include "rgb_box_blur_clipped_macros.svh"

module rbb_checker import rbb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input logic empty,
    input logic pop,
    input t_out o_out
);

    // A reset leaves no result waiting.
    `RBB_ASSERT_ALWAYS(a_empty_after_reset, i_clk, $past(!i_rst_n), empty)

    // A reset leaves the input side open.
    `RBB_ASSERT_ALWAYS(a_open_after_reset, i_clk, $past(!i_rst_n), !full)

    // A waiting result that is not taken stays as it is.
    `RBB_ASSERT_ON(a_hold_result, i_clk, i_rst_n, !empty && !pop, ##1 $stable(o_out))

endmodule

bind rgb_box_blur_clipped rbb_checker u_rbb_checker (.*);
